// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define GSI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define GSI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/gsi_pkg.sv =====
// Types and constants of the gradient stop interpolator.
// No dependencies.
package gsi_pkg;

  localparam int unsigned OffW  = 17;
  localparam int unsigned ChW   = 8;
  localparam int unsigned NumCh = 4;
  localparam int unsigned CfgW  = 4;
  localparam int unsigned SlotW = 3;
  localparam int unsigned NumW  = 25;  // lo*wlo + hi*whi + d/2 < 2^25

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdEval  = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [SlotW-1:0] stop_index;
    logic [OffW-1:0]  stop_offset;
    logic [ChW-1:0]   stop_red;
    logic [ChW-1:0]   stop_green;
    logic [ChW-1:0]   stop_blue;
    logic [ChW-1:0]   stop_alpha;
    logic [OffW-1:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [ChW-1:0] out_red;
    logic [ChW-1:0] out_green;
    logic [ChW-1:0] out_blue;
    logic [ChW-1:0] out_alpha;
  } out_item_t;

  // channel order: red, green, blue, alpha
  typedef struct packed {
    logic [OffW-1:0]             offset;
    logic [NumCh-1:0][ChW-1:0]   ch;
  } stop_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [OffW-1:0]  pos;
    stop_t            lo;
    stop_t            hi;
  } token_t;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] slot;
    stop_t            data;
  } stop_wr_t;

endpackage

// ===== design/gradient_stop_interpolator.sv =====
// Gradient stop interpolator: an evaluate item passes the cells of the search chain
// in turn (the accepting edge loads the first cell), then the weights, the products,
// eight steps of the shared divider and the output register; when the bracketing
// stops coincide, the products and the divider are skipped. One evaluate is in flight
// at a time; write items are taken one per cycle when idle. The next item is accepted
// while a result waits in the output register. Reset (async, low): stop_count = 1,
// pipeline empty; the stop table is not cleared.
`include "assert_macros.svh"
module gradient_stop_interpolator import gsi_pkg::*; #(
  parameter int unsigned MAX_STOPS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_item_o
);

  localparam int unsigned CntW = $clog2(MAX_STOPS + 1);

  logic [CfgW-1:0]      cnt_q;
  logic [CntW-1:0]      n_eff;
  token_t               tok [MAX_STOPS+1];
  logic [MAX_STOPS-1:0] chain_vld;
  stop_wr_t             wr;
  logic                 in_acc, ip_busy, res_valid, take, busy;
  out_item_t            res, out_q;
  logic                 out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cnt_q == '0) begin
      n_eff = CntW'(1);
    end else if (int'(cnt_q) > MAX_STOPS) begin
      n_eff = CntW'(MAX_STOPS);
    end else begin
      n_eff = CntW'(cnt_q);
    end
  end

  assign in_acc = in_valid_i && in_ready_o;

  assign wr.en   = in_acc && (in_item_i.cmd == CmdWrite);
  assign wr.slot = in_item_i.stop_index;
  assign wr.data = '{offset: in_item_i.stop_offset,
                     ch: {in_item_i.stop_alpha, in_item_i.stop_blue,
                          in_item_i.stop_green, in_item_i.stop_red}};

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = in_acc && (in_item_i.cmd == CmdEval);
    tok[0].pos   = in_item_i.position;
  end

  for (genvar i = 0; i < MAX_STOPS; i++) begin : g_cell
    gsi_cell #(.IDX(i), .CntW(CntW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_i    (wr),
      .count_i (n_eff),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1])
    );
    assign chain_vld[i] = tok[i+1].valid;
  end

  gsi_interp u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok[MAX_STOPS]),
    .take_i      (take),
    .busy_o      (ip_busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign busy       = (|chain_vld) || ip_busy;
  assign in_ready_o = !busy;
  assign take       = res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `GSI_ASSERT(a_eval_starts, clk_i, rst_ni,
              in_acc && in_item_i.cmd == CmdEval |=> busy, "evaluate item lost")
  `GSI_ASSERT(a_write_idle, clk_i, rst_ni,
              in_acc && in_item_i.cmd == CmdWrite |=> !busy, "write item started work")
  `GSI_ASSERT_NEVER(a_one_item, clk_i, rst_ni,
                    $countones({chain_vld, ip_busy}) > 1, "more than one item in flight")

endmodule

// ===== design/gsi_cell.sv =====
// One stop cell of the search chain: holds a stop, updates the passing token.
// Depends on gsi_pkg.
module gsi_cell import gsi_pkg::*; #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned CntW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stop_wr_t        wr_i,
  input  logic [CntW-1:0] count_i,
  input  token_t          tok_i,
  output token_t          tok_o
);

  stop_t  stop_q;
  token_t tok_d, tok_q;
  logic   vld_q;
  logic   in_use;

  assign in_use = (IDX < int'(count_i));

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.found && in_use) begin
      if (stop_q.offset >= tok_i.pos) begin
        tok_d.found = 1'b1;
        tok_d.hi    = stop_q;
        if (IDX == 0) begin
          tok_d.lo = stop_q;
        end
      end else begin
        tok_d.lo = stop_q;
        tok_d.hi = stop_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (int'(wr_i.slot) == IDX)) begin
      stop_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = vld_q;
  end

endmodule

// ===== design/gsi_interp.sv =====
// Interpolation unit: weights, products, and an 8-step restoring divider.
// Depends on gsi_pkg.
module gsi_interp import gsi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  token_t    tok_i,
  input  logic      take_i,
  output logic      busy_o,
  output logic      res_valid_o,
  output out_item_t res_o
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_e;

  state_e                    state_q;
  logic [OffW-1:0]           d_q, wlo_q, whi_q;
  logic [NumCh-1:0][ChW-1:0] lo_q, hi_q, quo_q;
  logic [NumCh-1:0][NumW-1:0] rem_q;
  logic [NumW-1:0]           dsh_q;
  logic [2:0]                step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (tok_i.valid) begin
            state_q <= (tok_i.hi.offset <= tok_i.lo.offset) ? S_DONE : S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_DIV;
          step_q  <= 3'd7;
        end
        S_DIV: begin
          step_q <= step_q - 3'd1;
          if (step_q == 3'd0) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        d_q   <= tok_i.hi.offset - tok_i.lo.offset;
        wlo_q <= tok_i.hi.offset - tok_i.pos;
        whi_q <= tok_i.pos - tok_i.lo.offset;
        lo_q  <= tok_i.lo.ch;
        hi_q  <= tok_i.hi.ch;
        quo_q <= tok_i.hi.ch;
      end
      S_MUL: begin
        for (int j = 0; j < NumCh; j++) begin
          rem_q[j] <= NumW'(lo_q[j] * wlo_q) + NumW'(hi_q[j] * whi_q)
                    + NumW'(d_q >> 1);
        end
        dsh_q <= NumW'({d_q, 7'd0});
      end
      S_DIV: begin
        for (int j = 0; j < NumCh; j++) begin
          if (rem_q[j] >= dsh_q) begin
            rem_q[j] <= rem_q[j] - dsh_q;
            quo_q[j] <= {quo_q[j][ChW-2:0], 1'b1};
          end else begin
            quo_q[j] <= {quo_q[j][ChW-2:0], 1'b0};
          end
        end
        dsh_q <= dsh_q >> 1;
      end
      default: ;
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = '{out_red: quo_q[0], out_green: quo_q[1],
                         out_blue: quo_q[2], out_alpha: quo_q[3]};

endmodule
